// File: rtl/core/flv_pkg.sv
// Shared types, constants and helpers of the flocking velocity update block.
`timescale 1ns / 1ps
package flv_pkg;

   localparam int MAX_BOIDS  = 64;
   localparam int IDX_W      = 6;
   localparam int COORD_W    = 32;
   localparam int CNT_W      = 7;
   localparam int GAIN_W     = 24;
   localparam int REPEL_W    = 31;
   localparam int DT_W       = 17;
   localparam int SUM_W      = 38;   // sum of 63 coordinates
   localparam int SEP_W      = 39;   // sum of 63 differences
   localparam int DIFF_W     = 33;
   localparam int DIV_W      = 6;
   localparam int K_W        = 25;
   localparam int PROD_W     = 59;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam int LANES      = 6;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_UPDATE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_BOID_COUNT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COHESION_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATION_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNMENT_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_GAIN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEL_DISTANCE  = 3'd6;

   typedef struct packed {
      kind_type                    kind;
      logic [IDX_W-1:0]            boid_index;
      logic signed [COORD_W-1:0]   in_pos_x;
      logic signed [COORD_W-1:0]   in_pos_y;
      logic signed [COORD_W-1:0]   in_pos_z;
      logic signed [COORD_W-1:0]   in_vel_x;
      logic signed [COORD_W-1:0]   in_vel_y;
      logic signed [COORD_W-1:0]   in_vel_z;
      logic [DT_W-1:0]             time_step;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]            out_index;
      logic signed [COORD_W-1:0]   out_pos_x;
      logic signed [COORD_W-1:0]   out_pos_y;
      logic signed [COORD_W-1:0]   out_pos_z;
      logic signed [COORD_W-1:0]   out_vel_x;
      logic signed [COORD_W-1:0]   out_vel_y;
      logic signed [COORD_W-1:0]   out_vel_z;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]   pos_x;
      logic signed [COORD_W-1:0]   pos_y;
      logic signed [COORD_W-1:0]   pos_z;
      logic signed [COORD_W-1:0]   vel_x;
      logic signed [COORD_W-1:0]   vel_y;
      logic signed [COORD_W-1:0]   vel_z;
   } boid_type;

   typedef struct packed {
      logic [GAIN_W-1:0] speed;
      logic [GAIN_W-1:0] cohesion;
      logic [GAIN_W-1:0] separation;
      logic [GAIN_W-1:0] alignment;
      logic [GAIN_W-1:0] origin;
   } steer_cfg_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

   // Clamp a wide signed value to the coordinate range.
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat_coord = COORD_W'(hi);
      end else if (v < lo) begin
         sat_coord = COORD_W'(lo);
      end else begin
         sat_coord = COORD_W'(v);
      end
   endfunction

endpackage

// File: rtl/core/flv_store.sv
// Boid entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module flv_store import flv_pkg::*; (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   output boid_type         rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  boid_type         wr_data
);

   boid_type mem [MAX_BOIDS];
   boid_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/flv_divider.sv
// Six-lane restoring divider, one quotient bit per lane per cycle, truncating.
`timescale 1ns / 1ps
module flv_divider import flv_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIV_W-1:0]          divisor,
   input  logic signed [SUM_W-1:0]   dividend [LANES],
   output logic signed [COORD_W-1:0] quotient [LANES],
   output logic                      done
);

   localparam int CNT_BITS = $clog2(SUM_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [DIV_W-1:0]     den_ff;
   logic [SUM_W-1:0]     num_ff [LANES];
   logic [DIV_W-1:0]     rem_ff [LANES];
   logic                 neg_ff [LANES];
   logic [DIV_W:0]       shifted [LANES];
   logic                 qbit [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         shifted[l] = {rem_ff[l], num_ff[l][SUM_W-1]};
         qbit[l]    = (shifted[l] >= {1'b0, den_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff  <= cnt_ff + 1'b1;
            busy_ff <= (cnt_ff != CNT_BITS'(SUM_W - 1));
            done_ff <= (cnt_ff == CNT_BITS'(SUM_W - 1));
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= divisor;
         for (int l = 0; l < LANES; l++) begin
            neg_ff[l] <= dividend[l][SUM_W-1];
            num_ff[l] <= dividend[l][SUM_W-1] ? SUM_W'(-dividend[l]) : SUM_W'(dividend[l]);
            rem_ff[l] <= '0;
         end
      end else if (busy_ff) begin
         for (int l = 0; l < LANES; l++) begin
            num_ff[l] <= {num_ff[l][SUM_W-2:0], qbit[l]};
            rem_ff[l] <= qbit[l] ? DIV_W'(shifted[l] - {1'b0, den_ff}) : shifted[l][DIV_W-1:0];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quotient[l] = neg_ff[l] ? sat_coord(-64'($signed({1'b0, num_ff[l]})))
                                 : sat_coord(64'($signed({1'b0, num_ff[l]})));
      end
   end

   assign done = done_ff;

endmodule

// File: rtl/core/flv_steer.sv
// Velocity and position chain, component by component, with a gain-by-time-step product and a term product.
`timescale 1ns / 1ps
module flv_steer import flv_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  unit_ctl_type              ctl_in,
   output unit_ctl_type              ctl_out,
   input  logic [DT_W-1:0]           dt,
   input  steer_cfg_type             cfg,
   input  boid_type                  self_in,
   input  logic signed [COORD_W-1:0] centre [3],
   input  logic signed [COORD_W-1:0] avg_vel [3],
   input  logic signed [COORD_W-1:0] sep [3],
   output boid_type                  result
);

   typedef enum logic [4:0] {
      STEP_COH = 5'b00001,
      STEP_SEP = 5'b00010,
      STEP_ALI = 5'b00100,
      STEP_ORG = 5'b01000,
      STEP_POS = 5'b10000
   } step_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_GAIN = 4'b0010,
      PH_MUL  = 4'b0100,
      PH_ADD  = 4'b1000
   } phase_type;

   phase_type                 phase_ff;
   step_type                  step_ff;
   logic [1:0]                c_ff;
   logic                      done_ff;
   logic [DT_W-1:0]           dt_ff;
   logic [K_W-1:0]            k_ff;
   logic signed [DIFF_W-1:0]  term_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [COORD_W-1:0] p_ff [3];
   logic signed [COORD_W-1:0] v_ff [3];
   logic signed [COORD_W-1:0] cen_ff [3];
   logic signed [COORD_W-1:0] avg_ff [3];
   logic signed [COORD_W-1:0] sep_ff [3];

   logic [GAIN_W-1:0]         gain;
   logic signed [DIFF_W-1:0]  term_in;
   logic signed [COORD_W-1:0] acc;
   logic signed [COORD_W-1:0] acc_in;
   logic signed [COORD_W-1:0] p_cur;
   logic signed [COORD_W-1:0] v_cur;
   logic                      last_step;

   assign p_cur = p_ff[c_ff];
   assign v_cur = v_ff[c_ff];
   assign last_step = (step_ff == STEP_POS) && (c_ff == 2'd2);

   always_comb begin
      case (step_ff)
         STEP_COH: begin
            gain    = cfg.cohesion;
            term_in = DIFF_W'(cen_ff[c_ff]) - DIFF_W'(p_cur);
         end
         STEP_SEP: begin
            gain    = cfg.separation;
            term_in = DIFF_W'(sep_ff[c_ff]);
         end
         STEP_ALI: begin
            gain    = cfg.alignment;
            term_in = DIFF_W'(avg_ff[c_ff]) - DIFF_W'(v_cur);
         end
         STEP_ORG: begin
            gain    = cfg.origin;
            term_in = -DIFF_W'(p_cur);
         end
         default: begin
            gain    = cfg.speed;
            term_in = DIFF_W'(v_cur);
         end
      endcase
      acc    = (step_ff == STEP_POS) ? p_cur : v_cur;
      acc_in = sat_coord(64'(acc) + 64'(prod_ff >>> 16));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= STEP_COH;
         c_ff     <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (phase_ff == PH_ADD) && last_step;
         case (phase_ff)
            PH_IDLE: begin
               if (ctl_in.start) begin
                  phase_ff <= PH_GAIN;
                  step_ff  <= STEP_COH;
                  c_ff     <= '0;
               end
            end
            PH_GAIN: phase_ff <= PH_MUL;
            PH_MUL:  phase_ff <= PH_ADD;
            PH_ADD: begin
               phase_ff <= last_step ? PH_IDLE : PH_GAIN;
               case (step_ff)
                  STEP_COH: step_ff <= STEP_SEP;
                  STEP_SEP: step_ff <= STEP_ALI;
                  STEP_ALI: step_ff <= STEP_ORG;
                  STEP_ORG: step_ff <= STEP_POS;
                  default: begin
                     step_ff <= STEP_COH;
                     if (c_ff != 2'd2) begin
                        c_ff <= c_ff + 1'b1;
                     end
                  end
               endcase
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == PH_IDLE && ctl_in.start) begin
         dt_ff     <= dt;
         p_ff[0]   <= self_in.pos_x;
         p_ff[1]   <= self_in.pos_y;
         p_ff[2]   <= self_in.pos_z;
         v_ff[0]   <= self_in.vel_x;
         v_ff[1]   <= self_in.vel_y;
         v_ff[2]   <= self_in.vel_z;
         cen_ff    <= centre;
         avg_ff    <= avg_vel;
         sep_ff    <= sep;
      end
      if (phase_ff == PH_GAIN) begin
         k_ff    <= K_W'(({24'd0, dt_ff} * {17'd0, gain}) >> 16);
         term_ff <= term_in;
      end
      if (phase_ff == PH_MUL) begin
         prod_ff <= PROD_W'($signed({1'b0, k_ff}) * term_ff);
      end
      if (phase_ff == PH_ADD) begin
         if (step_ff == STEP_POS) begin
            p_ff[c_ff] <= acc_in;
         end else begin
            v_ff[c_ff] <= acc_in;
         end
      end
   end

   assign result = '{pos_x: p_ff[0], pos_y: p_ff[1], pos_z: p_ff[2],
                     vel_x: v_ff[0], vel_y: v_ff[1], vel_z: v_ff[2]};
   assign ctl_out = '{start: 1'b0, done: done_ff};

endmodule

// File: rtl/core/flocking_velocity_update.sv
// Top level of the boid store and flocking velocity update.
`timescale 1ns / 1ps
// The block holds 64 boid entries (position and velocity, Q16.16) in one
// synchronous memory. An update reads its own entry, then walks entries
// 0..min(boid_count,64)-1 through a four-stage scan pipeline at one entry per
// cycle (the memory read port sets this), divides the sums in a six-lane
// bit-serial divider and runs the steering chain, which multiplies the time
// step by a gain and that product by a term. Items are taken one at a time; a
// finished response waits in the output register while the next transaction is accepted.
module flocking_velocity_update import flv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_READ   = 9'b000000010,
      ST_SELF   = 9'b000000100,
      ST_SCAN   = 9'b000001000,
      ST_DRAIN  = 9'b000010000,
      ST_DIVIDE = 9'b000100000,
      ST_STEER  = 9'b001000000,
      ST_WRITE  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   // configuration
   logic [CNT_W-1:0]   count_ff;
   steer_cfg_type      gains_ff;
   logic [REPEL_W-1:0] repel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(1);
         gains_ff <= '{speed: GAIN_W'(65536), default: '0};
         repel_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BOID_COUNT:      count_ff            <= csr_wdata[CNT_W-1:0];
            CSR_SPEED_GAIN:      gains_ff.speed      <= csr_wdata[GAIN_W-1:0];
            CSR_COHESION_GAIN:   gains_ff.cohesion   <= csr_wdata[GAIN_W-1:0];
            CSR_SEPARATION_GAIN: gains_ff.separation <= csr_wdata[GAIN_W-1:0];
            CSR_ALIGNMENT_GAIN:  gains_ff.alignment  <= csr_wdata[GAIN_W-1:0];
            CSR_ORIGIN_GAIN:     gains_ff.origin     <= csr_wdata[GAIN_W-1:0];
            CSR_REPEL_DISTANCE:  repel_ff            <= csr_wdata[REPEL_W-1:0];
            default: ;
         endcase
      end
   end

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [DT_W-1:0]  dt_ff;
   logic [CNT_W-1:0] i_ff;
   boid_type         self_ff;
   boid_type         res_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic [2*REPEL_W-1:0] r2_ff;

   logic       accept;
   logic       slot_free;
   logic [CNT_W-1:0] n_lim;
   logic [DIV_W-1:0] divisor;
   logic       last_issue;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign n_lim     = (count_ff > CNT_W'(MAX_BOIDS)) ? CNT_W'(MAX_BOIDS) : count_ff;
   assign divisor   = (n_lim > CNT_W'(1)) ? DIV_W'(n_lim - 1'b1) : DIV_W'(1);
   assign last_issue = (i_ff == n_lim - 1'b1);

   // memory
   logic [IDX_W-1:0] mem_rd_addr;
   boid_type         mem_rd_data;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wr_addr;
   boid_type         mem_wr_data;
   boid_type         load_data;
   boid_type         steer_result;

   assign load_data = '{pos_x: req_data.in_pos_x, pos_y: req_data.in_pos_y,
                        pos_z: req_data.in_pos_z, vel_x: req_data.in_vel_x,
                        vel_y: req_data.in_vel_y, vel_z: req_data.in_vel_z};

   always_comb begin
      case (state_ff)
         ST_IDLE: mem_rd_addr = req_data.boid_index;
         ST_SCAN: mem_rd_addr = i_ff[IDX_W-1:0];
         default: mem_rd_addr = idx_ff;
      endcase
   end

   // a load writes on acceptance; an update writes its entry back once
   assign mem_we      = (accept && req_data.kind == KIND_LOAD) || (state_ff == ST_WRITE);
   assign mem_wr_addr = (state_ff == ST_IDLE) ? req_data.boid_index : idx_ff;
   assign mem_wr_data = (state_ff == ST_IDLE) ? load_data : steer_result;

   flv_store u_store (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // scan pipeline: read, difference, square, compare and accumulate
   logic v0_ff;
   logic v1_ff;
   logic v2_ff;
   logic signed [COORD_W-1:0] o_pos [3];
   logic signed [COORD_W-1:0] o_vel [3];
   logic signed [COORD_W-1:0] s_pos [3];
   logic signed [DIFF_W-1:0]  d1 [3];
   logic [DIFF_W-1:0]         ad1 [3];
   logic                      near1;
   logic signed [DIFF_W-1:0]  d1_ff [3];
   logic [REPEL_W-1:0]        ad1_ff [3];
   logic                      near1_ff;
   logic signed [DIFF_W-1:0]  d2_ff [3];
   logic [2*REPEL_W-1:0]      sq2_ff [3];
   logic                      near2_ff;
   logic [63:0]               dist2;
   logic signed [SUM_W-1:0]   sum_p_ff [3];
   logic signed [SUM_W-1:0]   sum_v_ff [3];
   logic signed [SEP_W-1:0]   sum_k_ff [3];

   assign o_pos = '{mem_rd_data.pos_x, mem_rd_data.pos_y, mem_rd_data.pos_z};
   assign o_vel = '{mem_rd_data.vel_x, mem_rd_data.vel_y, mem_rd_data.vel_z};
   assign s_pos = '{self_ff.pos_x, self_ff.pos_y, self_ff.pos_z};

   always_comb begin
      near1 = 1'b1;
      for (int c = 0; c < 3; c++) begin
         d1[c]  = DIFF_W'(s_pos[c]) - DIFF_W'(o_pos[c]);
         ad1[c] = d1[c][DIFF_W-1] ? DIFF_W'(-d1[c]) : DIFF_W'(d1[c]);
         near1  = near1 && (ad1[c] < {2'b00, repel_ff});
      end
      dist2 = 64'(sq2_ff[0]) + 64'(sq2_ff[1]) + 64'(sq2_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         // skip the entry being updated
         v0_ff <= (state_ff == ST_SCAN) && (i_ff != {1'b0, idx_ff});
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int c = 0; c < 3; c++) begin
            sum_p_ff[c] <= '0;
            sum_v_ff[c] <= '0;
            sum_k_ff[c] <= '0;
         end
      end else begin
         if (v0_ff) begin
            for (int c = 0; c < 3; c++) begin
               sum_p_ff[c] <= sum_p_ff[c] + SUM_W'(o_pos[c]);
               sum_v_ff[c] <= sum_v_ff[c] + SUM_W'(o_vel[c]);
            end
         end
         if (v2_ff && near2_ff && dist2 < {2'b00, r2_ff}) begin
            for (int c = 0; c < 3; c++) begin
               sum_k_ff[c] <= sum_k_ff[c] + SEP_W'(d2_ff[c]);
            end
         end
      end
      for (int c = 0; c < 3; c++) begin
         d1_ff[c]  <= d1[c];
         ad1_ff[c] <= ad1[c][REPEL_W-1:0];
         d2_ff[c]  <= d1_ff[c];
         sq2_ff[c] <= ad1_ff[c] * ad1_ff[c];
      end
      near1_ff <= near1;
      near2_ff <= near1_ff;
   end

   // division of the sums and the steering chain
   unit_ctl_type             div_ctl;
   unit_ctl_type             steer_ctl_in;
   unit_ctl_type             steer_ctl_out;
   logic signed [SUM_W-1:0]   div_in [LANES];
   logic signed [COORD_W-1:0] div_out [LANES];
   logic signed [COORD_W-1:0] centre [3];
   logic signed [COORD_W-1:0] avg_vel [3];
   logic signed [COORD_W-1:0] sep [3];

   assign div_ctl.start = (state_ff == ST_DRAIN) && !v0_ff && !v1_ff && !v2_ff;
   assign div_in = '{sum_p_ff[0], sum_p_ff[1], sum_p_ff[2],
                     sum_v_ff[0], sum_v_ff[1], sum_v_ff[2]};

   flv_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .divisor  (divisor),
      .dividend (div_in),
      .quotient (div_out),
      .done     (div_ctl.done)
   );

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         centre[c]  = div_out[c];
         avg_vel[c] = div_out[c+3];
         sep[c]     = sat_coord(64'(sum_k_ff[c]));
      end
   end

   assign steer_ctl_in = '{start: div_ctl.done, done: 1'b0};

   flv_steer u_steer (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (steer_ctl_in),
      .ctl_out (steer_ctl_out),
      .dt      (dt_ff),
      .cfg     (gains_ff),
      .self_in (self_ff),
      .centre  (centre),
      .avg_vel (avg_vel),
      .sep     (sep),
      .result  (steer_result)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load the output register when it frees up, else drop valid once taken
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_data.kind)
                     KIND_LOAD:   state_ff <= ST_DONE;
                     KIND_UPDATE: state_ff <= ST_SELF;
                     default:     state_ff <= ST_READ;
                  endcase
               end
            end
            ST_READ: state_ff <= ST_DONE;
            ST_SELF: state_ff <= (n_lim == '0) ? ST_DRAIN : ST_SCAN;
            ST_SCAN: begin
               if (last_issue) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (div_ctl.start) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_ctl.done) begin
                  state_ff <= ST_STEER;
               end
            end
            ST_STEER: begin
               if (steer_ctl_out.done) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: state_ff <= ST_DONE;
            ST_DONE: begin
               // hold the result until the output register is free
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff <= req_data.boid_index;
         dt_ff  <= req_data.time_step;
         i_ff   <= '0;
         res_ff <= load_data;
      end
      if (state_ff == ST_SCAN) begin
         i_ff <= i_ff + 1'b1;
      end
      if (state_ff == ST_READ) begin
         res_ff <= mem_rd_data;
      end
      if (state_ff == ST_SELF) begin
         self_ff <= mem_rd_data;
         r2_ff   <= repel_ff * repel_ff;
      end
      if (state_ff == ST_WRITE) begin
         res_ff <= steer_result;
      end
      if (state_ff == ST_DONE && slot_free) begin
         rsp_data_ff <= '{out_index: idx_ff,
                          out_pos_x: res_ff.pos_x, out_pos_y: res_ff.pos_y,
                          out_pos_z: res_ff.pos_z, out_vel_x: res_ff.vel_x,
                          out_vel_y: res_ff.vel_y, out_vel_z: res_ff.vel_z};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // memory writes only on a load acceptance or an update write-back
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE || state_ff == ST_WRITE))
      else $error("memory write outside load or write-back");

   // no scan work may be in flight once a new transaction can be taken
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!v0_ff && !v1_ff && !v2_ff))
      else $error("scan pipeline busy while idle");

   // a finished transaction always lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free) |=> rsp_valid_ff)
      else $error("response lost");

   // the divider starts only after the scan has drained
   assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> (state_ff == ST_DRAIN))
      else $error("divider started during scan");

endmodule
